>>> design/tosc_pkg.sv
// shared types and constants for the triangle oscillator with adsr envelope
package tosc_pkg;

    // envelope level and level registers use 32768 as full scale
    localparam int unsigned LEVEL_W   = 16;
    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned INC_W     = 15;
    localparam int unsigned SAMPLE_W  = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // intermediate envelope math: signed, wide enough for peak overshoot and undershoot
    localparam int unsigned ENV_ACC_W = 19;

    localparam logic [LEVEL_W-1:0]          LEVEL_ONE     = 16'h8000;
    localparam logic signed [ENV_ACC_W-1:0] ACC_LEVEL_ONE = 19'sd32768;
    localparam logic [SAMPLE_W-1:0]         SAMPLE_MAX    = 15'h7fff;

    typedef enum logic [1:0] {
        ENV_ATTACK  = 2'd0,
        ENV_DECAY   = 2'd1,
        ENV_SUSTAIN = 2'd2,
        ENV_RELEASE = 2'd3
    } t_env_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_INC    = 3'd0,
        CFG_RIGHT_INC   = 3'd1,
        CFG_ATTACK_STEP = 3'd2,
        CFG_PEAK_LEVEL  = 3'd3,
        CFG_DECAY_STEP  = 3'd4,
        CFG_SUSTAIN_LVL = 3'd5,
        CFG_SUSTAIN_BUF = 3'd6,
        CFG_RELEASE_STP = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [15:0]        sustain_buffers;
        logic [LEVEL_W-1:0] release_step;
    } t_env_cfg;

endpackage

>>> design/tosc_scale.sv
// magnitude of a q1.15 phase times the envelope level, saturated
module tosc_scale import tosc_pkg::*; (
    input  logic signed [PHASE_W-1:0] i_phase,
    input  logic [LEVEL_W-1:0]        i_level,
    output logic [SAMPLE_W-1:0]       o_sample
);

    logic [PHASE_W-1:0]          mag;
    logic [PHASE_W+LEVEL_W-1:0]  prod;

    // -32768 maps to 32768, which still fits unsigned
    assign mag  = i_phase[PHASE_W-1] ? PHASE_W'(-i_phase) : PHASE_W'(i_phase);
    assign prod = mag * i_level;

    // shifted product above 32767 shows in the top two bits
    assign o_sample = (prod[PHASE_W+LEVEL_W-1 -: 2] != 2'b00) ? SAMPLE_MAX
                                                               : prod[SAMPLE_W+14:15];

endmodule

>>> design/tosc_env.sv
// adsr envelope state and its per-buffer step
module tosc_env import tosc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_env_cfg           i_cfg,
    output logic [LEVEL_W-1:0] o_level
);

    t_env_mode          r_mode,    n_mode;
    logic [LEVEL_W-1:0] r_level,   n_level;
    logic [15:0]        r_elapsed, n_elapsed;

    logic signed [ENV_ACC_W-1:0] lv;
    logic signed [ENV_ACC_W-1:0] peak, sus;

    assign peak = $signed({3'b000, i_cfg.peak_level});
    assign sus  = $signed({3'b000, i_cfg.sustain_level});

    // next state: rules in order, each sees the ones before it
    always_comb begin
        lv        = $signed({3'b000, r_level});
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        if (n_mode == ENV_ATTACK && lv < peak) begin
            lv = lv + $signed({3'b000, i_cfg.attack_step});
        end
        if (n_mode == ENV_ATTACK && lv >= peak) begin
            n_mode = ENV_DECAY;
        end
        if (n_mode == ENV_DECAY && lv > sus) begin
            lv = lv - $signed({3'b000, i_cfg.decay_step});
        end
        if (n_mode == ENV_DECAY && lv <= sus) begin
            n_mode = ENV_SUSTAIN;
        end
        if (n_mode == ENV_SUSTAIN && n_elapsed < i_cfg.sustain_buffers) begin
            n_elapsed = n_elapsed + 16'd1;
        end
        if (n_mode == ENV_SUSTAIN && n_elapsed >= i_cfg.sustain_buffers) begin
            n_mode = ENV_RELEASE;
        end
        if (n_mode == ENV_RELEASE && lv > 0) begin
            lv = lv - $signed({3'b000, i_cfg.release_step});
        end
    end

    // clamp to 0..1.0
    always_comb begin
        if (lv < 0) begin
            n_level = '0;
        end else if (lv > ACC_LEVEL_ONE) begin
            n_level = LEVEL_ONE;
        end else begin
            n_level = lv[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ENV_ATTACK;
            r_level   <= '0;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_level   <= n_level;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_level = r_level;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_ONE)
        else $error("envelope level above full scale");

    a_release_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == ENV_RELEASE |=> r_mode == ENV_RELEASE)
        else $error("envelope left release");

    a_elapsed_in_sustain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_elapsed) |-> $past(i_step) && $past(r_mode) != ENV_RELEASE)
        else $error("sustain counter moved outside a sustain step");
`endif

endmodule

>>> design/triangle_oscillator_adsr.sv
// top level: stereo phase-accumulator oscillator with adsr envelope
//
// Each input beat is one frame tick; each tick gives exactly one output beat
// holding the left and right samples, |phase| * envelope in q1.15, saturated
// to 32767. Samples use the phases and envelope level as they stand before the
// tick; the phases then advance by their increments (wrapping from +1 to -1)
// and, on a tick whose buffer_end bit is set, the envelope takes one adsr step.
// Throughput is one beat per cycle when not stalled: the whole tick is one pass
// through two 16x16 multipliers into the output register, and the envelope step
// is a short add/compare chain. The output beat is valid in the next cycle. The
// input is taken whenever the output register is empty or being drained this
// cycle. Configuration is a plain write port (enable, 3-bit index, 16-bit
// data), effective on the next tick; there is no read-back and no retrigger.
module triangle_oscillator_adsr import tosc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // frame tick stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,  // [0] buffer_end, [7:1] zero
    // sample stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata   // [14:0] left_sample, [29:15] right_sample, [31:30] zero
);

    // config registers
    logic [INC_W-1:0] r_left_inc;
    logic [INC_W-1:0] r_right_inc;
    t_env_cfg         r_env_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_inc                <= INC_W'(328);
            r_right_inc               <= INC_W'(983);
            r_env_cfg.attack_step     <= 16'd328;
            r_env_cfg.peak_level      <= LEVEL_ONE;
            r_env_cfg.decay_step      <= 16'd328;
            r_env_cfg.sustain_level   <= 16'd29491;
            r_env_cfg.sustain_buffers <= 16'd300;
            r_env_cfg.release_step    <= 16'd3277;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_INC:    r_left_inc                <= i_cfg_data[INC_W-1:0];
                CFG_RIGHT_INC:   r_right_inc               <= i_cfg_data[INC_W-1:0];
                CFG_ATTACK_STEP: r_env_cfg.attack_step     <= i_cfg_data;
                CFG_PEAK_LEVEL:  r_env_cfg.peak_level      <= i_cfg_data;
                CFG_DECAY_STEP:  r_env_cfg.decay_step      <= i_cfg_data;
                CFG_SUSTAIN_LVL: r_env_cfg.sustain_level   <= i_cfg_data;
                CFG_SUSTAIN_BUF: r_env_cfg.sustain_buffers <= i_cfg_data;
                CFG_RELEASE_STP: r_env_cfg.release_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: one output register, refilled in the cycle it drains
    logic s_beat;
    logic r_out_valid;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_beat     = i_s_tvalid && o_s_tready;

    // phase accumulators, 16-bit wrap matches +1 -> -1
    logic signed [PHASE_W-1:0] r_left_phase,  n_left_phase;
    logic signed [PHASE_W-1:0] r_right_phase, n_right_phase;

    assign n_left_phase  = r_left_phase  + $signed({1'b0, r_left_inc});
    assign n_right_phase = r_right_phase + $signed({1'b0, r_right_inc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_phase  <= '0;
            r_right_phase <= '0;
        end else if (s_beat) begin
            r_left_phase  <= n_left_phase;
            r_right_phase <= n_right_phase;
        end
    end

    // envelope steps only on the last frame of a buffer
    logic [LEVEL_W-1:0] env_level;

    tosc_env u_env (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_beat && i_s_tdata[0]),
        .i_cfg   (r_env_cfg),
        .o_level (env_level)
    );

    // one multiplier per channel, from the pre-tick state
    logic [SAMPLE_W-1:0] left_sample, right_sample;

    tosc_scale u_scale_left (
        .i_phase  (r_left_phase),
        .i_level  (env_level),
        .o_sample (left_sample)
    );

    tosc_scale u_scale_right (
        .i_phase  (r_right_phase),
        .i_level  (env_level),
        .o_sample (right_sample)
    );

    // output register
    logic [SAMPLE_W-1:0] r_left_out, r_right_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_left_out  <= left_sample;
            r_right_out <= right_sample;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_right_out, r_left_out};

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output register is stalled");

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("input beat produced no output beat");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !i_s_tvalid |=> !o_m_tvalid)
        else $error("output beat repeated after drain");
`endif

endmodule
